/* rtl/core/mcas_pkg.sv */
// ----------------------------------------------------------------------------
// mcas_pkg
// Shared types, codes and constants of the memory-card access sequencer.
// ----------------------------------------------------------------------------
package mcas_pkg;

    // Number of card devices that carry a pending bit of their own.
    localparam int NUM_DEVICES = 8;

    localparam int MODE_W      = 3;
    localparam int DEV_W       = 3;
    localparam int EVENT_W     = 3;
    localparam int RESULT_W    = 4;
    localparam int ACTION_W    = 4;
    localparam int MASK_W      = 8;
    localparam int RETRY_W     = 5;
    localparam int LOAD_LIM_W  = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;

    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam logic [MODE_W-1:0] MODE_INIT   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DIR    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CREATE = 3'd4;

    localparam logic [EVENT_W-1:0] EV_NONE = 3'd0;
    localparam logic [EVENT_W-1:0] EV_IOE  = 3'd1;
    localparam logic [EVENT_W-1:0] EV_ERR  = 3'd2;
    localparam logic [EVENT_W-1:0] EV_TMO  = 3'd3;
    localparam logic [EVENT_W-1:0] EV_NEW  = 3'd4;

    localparam logic [ACTION_W-1:0] ACT_NONE     = 4'd0;
    localparam logic [ACTION_W-1:0] ACT_INFO     = 4'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR    = 4'd2;
    localparam logic [ACTION_W-1:0] ACT_LOAD     = 4'd3;
    localparam logic [ACTION_W-1:0] ACT_DIR      = 4'd4;
    localparam logic [ACTION_W-1:0] ACT_CREATE   = 4'd5;
    localparam logic [ACTION_W-1:0] ACT_OPEN     = 4'd6;
    localparam logic [ACTION_W-1:0] ACT_SEEK     = 4'd7;
    localparam logic [ACTION_W-1:0] ACT_TRANSFER = 4'd8;

    localparam logic [RESULT_W-1:0] RES_ABSENT      = 4'd0;
    localparam logic [RESULT_W-1:0] RES_BUSY        = 4'd1;
    localparam logic [RESULT_W-1:0] RES_NEW_CARD    = 4'd2;
    localparam logic [RESULT_W-1:0] RES_READY       = 4'd3;
    localparam logic [RESULT_W-1:0] RES_UNFORMATTED = 4'd4;
    localparam logic [RESULT_W-1:0] RES_DIR_NEW     = 4'd5;
    localparam logic [RESULT_W-1:0] RES_DIR_OK      = 4'd6;
    localparam logic [RESULT_W-1:0] RES_CREATE_FAIL = 4'd7;
    localparam logic [RESULT_W-1:0] RES_OPEN_FAIL   = 4'd8;
    localparam logic [RESULT_W-1:0] RES_SEEK_FAIL   = 4'd9;
    localparam logic [RESULT_W-1:0] RES_IO_FAIL     = 4'd10;
    localparam logic [RESULT_W-1:0] RES_DONE        = 4'd11;

    localparam logic [CFG_INDEX_W-1:0] CFG_FILE_RETRY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOAD_RETRY = 2'd1;

    localparam logic [RETRY_W-1:0]    FILE_RETRY_RESET = 5'd15;
    localparam logic [LOAD_LIM_W-1:0] LOAD_RETRY_RESET = 4'd3;
    localparam logic [RETRY_W-1:0]    RETRY_SAT        = 5'd31;
    localparam logic [MASK_W-1:0]     PENDING_RESET    = 8'hFF;
    localparam logic [MASK_W-1:0]     GROUP_LOW        = 8'h0F;
    localparam logic [MASK_W-1:0]     GROUP_HIGH       = 8'hF0;
    localparam logic [MASK_W-1:0]     DEV_MASK         = MASK_W'((1 << NUM_DEVICES) - 1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_INIT,
        PH_CHECK,
        PH_LOAD,
        PH_DIR,
        PH_CREATE,
        PH_OPEN,
        PH_XFER
    } phase_t;

    typedef enum logic [1:0] {
        SUB_ENTRY,
        SUB_ISSUE,
        SUB_WAIT,
        SUB_DATA
    } sub_t;

    typedef struct packed {
        logic                op;
        logic [MODE_W-1:0]   req_mode;
        logic [DEV_W-1:0]    device;
        logic                call_ok;
        logic [EVENT_W-1:0]  card_event;
    } item_t;

    typedef struct packed {
        logic                accepted;
        logic [RESULT_W-1:0] result_code;
        logic                is_idle;
        logic [ACTION_W-1:0] action;
        logic                close_file;
        logic [MASK_W-1:0]   pending_mask;
    } result_t;

    typedef struct packed {
        phase_t              phase;
        sub_t                sub_step;
        logic [MODE_W-1:0]   access_mode;
        logic [DEV_W-1:0]    device_reg;
        logic [MASK_W-1:0]   pending_bits;
        logic [RETRY_W-1:0]  retry_count;
        logic                new_card_flag;
        logic [RESULT_W-1:0] last_result;
    } seq_state_t;

    typedef struct packed {
        logic [RETRY_W-1:0]    file_retry_limit;
        logic [LOAD_LIM_W-1:0] load_retry_limit;
    } cfg_t;

endpackage

/* rtl/core/mcas_ifs.sv */
// ----------------------------------------------------------------------------
// mcas_ifs
// Handshake channels of the sequencer: item, result and configuration write.
// ----------------------------------------------------------------------------
interface mcas_item_if;
    logic                           valid;
    logic                           ready;
    logic                           op;
    logic [mcas_pkg::MODE_W-1:0]    req_mode;
    logic [mcas_pkg::DEV_W-1:0]     device;
    logic                           call_ok;
    logic [mcas_pkg::EVENT_W-1:0]   card_event;

    modport source (output valid, op, req_mode, device, call_ok, card_event, input ready);
    modport sink   (input valid, op, req_mode, device, call_ok, card_event, output ready);
endinterface

interface mcas_result_if;
    logic                           valid;
    logic                           ready;
    logic                           accepted;
    logic [mcas_pkg::RESULT_W-1:0]  result_code;
    logic                           is_idle;
    logic [mcas_pkg::ACTION_W-1:0]  action;
    logic                           close_file;
    logic [mcas_pkg::MASK_W-1:0]    pending_mask;

    modport source (output valid, accepted, result_code, is_idle, action, close_file,
                    pending_mask, input ready);
    modport sink   (input valid, accepted, result_code, is_idle, action, close_file,
                    pending_mask, output ready);
endinterface

interface mcas_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [mcas_pkg::CFG_INDEX_W-1:0]  index;
    logic [mcas_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/mcas_cfg_regs.sv */
// ----------------------------------------------------------------------------
// mcas_cfg_regs
// Retry limit registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module mcas_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    mcas_cfg_if.sink      cfg,
    output mcas_pkg::cfg_t limits
);

    mcas_pkg::cfg_t limits_reg;
    mcas_pkg::cfg_t limits_next;
    logic           cfg_xfer;

    // Writes are always taken; an unknown index is dropped.
    assign cfg.ready = 1'b1;
    assign cfg_xfer  = cfg.valid & cfg.ready;

    always_comb
    begin
        limits_next = limits_reg;
        if (cfg_xfer)
        begin
            case (cfg.index)
                mcas_pkg::CFG_FILE_RETRY:
                    limits_next.file_retry_limit = cfg.data[mcas_pkg::RETRY_W-1:0];
                mcas_pkg::CFG_LOAD_RETRY:
                    limits_next.load_retry_limit = cfg.data[mcas_pkg::LOAD_LIM_W-1:0];
                default:
                    limits_next = limits_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.file_retry_limit <= mcas_pkg::FILE_RETRY_RESET;
            limits_reg.load_retry_limit <= mcas_pkg::LOAD_RETRY_RESET;
        end
        else
        begin
            limits_reg <= limits_next;
        end
    end

    assign limits = limits_reg;

endmodule

/* rtl/core/mcas_step.sv */
// ----------------------------------------------------------------------------
// mcas_step
// Phase state machine: next state and result item for one input item.
// ----------------------------------------------------------------------------
module mcas_step (
    input  mcas_pkg::seq_state_t state,
    input  mcas_pkg::item_t      item,
    input  mcas_pkg::cfg_t       limits,
    output mcas_pkg::seq_state_t state_next,
    output mcas_pkg::result_t    result
);

    logic                              tick_active;
    logic                              req_taken;
    logic                              entry;
    mcas_pkg::sub_t                    sub_eff;
    logic [mcas_pkg::RETRY_W-1:0]      retry_base;
    logic [mcas_pkg::RETRY_W-1:0]      retry_inc;
    logic                              file_give_up;
    logic                              load_retry_left;
    logic                              dev_in_range;
    logic [mcas_pkg::MASK_W-1:0]       dev_onehot;
    logic                              dev_pending;
    logic [mcas_pkg::MASK_W-1:0]       group_bits;
    logic                              xfer_mode_ok;
    logic                              ev_ioe;
    logic                              ev_err;
    logic                              ev_tmo;
    logic                              ev_new;
    logic [mcas_pkg::ACTION_W-1:0]     action;
    logic                              close_file;
    logic [mcas_pkg::RESULT_W-1:0]     res_code;

    assign tick_active = (item.op == mcas_pkg::OP_TICK) && (state.phase != mcas_pkg::PH_IDLE);
    assign req_taken   = (item.op == mcas_pkg::OP_REQUEST) && (state.phase == mcas_pkg::PH_IDLE);

    // The first tick of a phase (other than directory) restarts the retry
    // count and moves to the issue step before the phase logic runs.
    assign entry      = (state.sub_step == mcas_pkg::SUB_ENTRY) &&
                        (state.phase != mcas_pkg::PH_DIR);
    assign sub_eff    = entry ? mcas_pkg::SUB_ISSUE : state.sub_step;
    assign retry_base = entry ? '0 : state.retry_count;
    assign retry_inc  = retry_base + mcas_pkg::RETRY_W'(1);

    assign file_give_up    = (retry_base >= limits.file_retry_limit);
    assign load_retry_left = (retry_base < {1'b0, limits.load_retry_limit});

    assign dev_in_range = ({1'b0, state.device_reg} < (mcas_pkg::DEV_W + 1)'(mcas_pkg::NUM_DEVICES));
    assign dev_onehot   = dev_in_range ? (mcas_pkg::MASK_W'(1) << state.device_reg) : '0;
    assign dev_pending  = !dev_in_range || state.pending_bits[state.device_reg];
    assign group_bits   = (state.device_reg[mcas_pkg::DEV_W-1] ? mcas_pkg::GROUP_HIGH
                                                              : mcas_pkg::GROUP_LOW)
                          & mcas_pkg::DEV_MASK;
    assign xfer_mode_ok = state.access_mode inside {mcas_pkg::MODE_READ, mcas_pkg::MODE_WRITE,
                                                    mcas_pkg::MODE_CREATE};

    // Event codes above new card match none of these and count as no event.
    assign ev_ioe = (item.card_event == mcas_pkg::EV_IOE);
    assign ev_err = (item.card_event == mcas_pkg::EV_ERR);
    assign ev_tmo = (item.card_event == mcas_pkg::EV_TMO);
    assign ev_new = (item.card_event == mcas_pkg::EV_NEW);

    // Outputs of the tick: primitive issued, file close and result code.
    always_comb
    begin
        action     = mcas_pkg::ACT_NONE;
        close_file = 1'b0;
        res_code   = mcas_pkg::RES_BUSY;
        if (tick_active)
        begin
            case (state.phase)
                mcas_pkg::PH_INIT:
                begin
                    if (sub_eff == mcas_pkg::SUB_ISSUE)
                    begin
                        action = mcas_pkg::ACT_INFO;
                    end
                    else if (sub_eff == mcas_pkg::SUB_WAIT)
                    begin
                        if (ev_ioe && state.access_mode == mcas_pkg::MODE_INIT)
                            res_code = mcas_pkg::RES_READY;
                        else if (ev_new && state.access_mode == mcas_pkg::MODE_INIT)
                            res_code = mcas_pkg::RES_NEW_CARD;
                        else if (ev_tmo)
                            res_code = mcas_pkg::RES_ABSENT;
                    end
                end
                mcas_pkg::PH_CHECK:
                begin
                    if (sub_eff == mcas_pkg::SUB_ISSUE)
                        action = mcas_pkg::ACT_CLEAR;
                    else if (sub_eff == mcas_pkg::SUB_WAIT && ev_tmo)
                        res_code = mcas_pkg::RES_ABSENT;
                end
                mcas_pkg::PH_LOAD:
                begin
                    if (sub_eff == mcas_pkg::SUB_ISSUE)
                    begin
                        action = mcas_pkg::ACT_LOAD;
                    end
                    else if (sub_eff == mcas_pkg::SUB_WAIT)
                    begin
                        if (ev_new && !load_retry_left)
                            res_code = mcas_pkg::RES_UNFORMATTED;
                        else if (ev_tmo)
                            res_code = mcas_pkg::RES_ABSENT;
                    end
                end
                mcas_pkg::PH_DIR:
                begin
                    action   = mcas_pkg::ACT_DIR;
                    res_code = state.new_card_flag ? mcas_pkg::RES_DIR_NEW
                                                   : mcas_pkg::RES_DIR_OK;
                end
                mcas_pkg::PH_CREATE:
                begin
                    if (sub_eff == mcas_pkg::SUB_ISSUE)
                    begin
                        action = mcas_pkg::ACT_CREATE;
                        if (item.call_ok)
                            close_file = 1'b1;
                        else if (file_give_up)
                            res_code = mcas_pkg::RES_CREATE_FAIL;
                    end
                end
                mcas_pkg::PH_OPEN:
                begin
                    if (sub_eff == mcas_pkg::SUB_ISSUE)
                    begin
                        action = mcas_pkg::ACT_OPEN;
                        if (!item.call_ok && file_give_up)
                            res_code = mcas_pkg::RES_OPEN_FAIL;
                    end
                end
                mcas_pkg::PH_XFER:
                begin
                    case (sub_eff)
                        mcas_pkg::SUB_ISSUE:
                        begin
                            action = mcas_pkg::ACT_SEEK;
                            if (!item.call_ok && file_give_up)
                                res_code = mcas_pkg::RES_SEEK_FAIL;
                        end
                        mcas_pkg::SUB_WAIT:
                        begin
                            action = mcas_pkg::ACT_TRANSFER;
                            if (!(item.call_ok && xfer_mode_ok) && file_give_up)
                            begin
                                res_code   = mcas_pkg::RES_IO_FAIL;
                                close_file = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (ev_ioe)
                            begin
                                res_code   = mcas_pkg::RES_DONE;
                                close_file = 1'b1;
                            end
                            else if (ev_tmo)
                            begin
                                res_code   = mcas_pkg::RES_ABSENT;
                                close_file = 1'b1;
                            end
                            else if (ev_new)
                            begin
                                res_code   = mcas_pkg::RES_IO_FAIL;
                                close_file = 1'b1;
                            end
                        end
                    endcase
                end
                default:
                begin
                    res_code = mcas_pkg::RES_BUSY;
                end
            endcase
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state;
        if (req_taken)
        begin
            state_next.access_mode   = item.req_mode;
            state_next.device_reg    = item.device;
            state_next.new_card_flag = 1'b0;
            if (item.req_mode inside {mcas_pkg::MODE_INIT, mcas_pkg::MODE_DIR})
            begin
                state_next.phase    = mcas_pkg::PH_INIT;
                state_next.sub_step = mcas_pkg::SUB_ENTRY;
            end
            else if (item.req_mode inside {mcas_pkg::MODE_READ, mcas_pkg::MODE_WRITE})
            begin
                state_next.phase    = mcas_pkg::PH_OPEN;
                state_next.sub_step = mcas_pkg::SUB_ENTRY;
            end
            else if (item.req_mode == mcas_pkg::MODE_CREATE)
            begin
                state_next.phase    = mcas_pkg::PH_CREATE;
                state_next.sub_step = mcas_pkg::SUB_ENTRY;
            end
        end
        else if (tick_active)
        begin
            state_next.sub_step    = sub_eff;
            state_next.retry_count = retry_base;
            state_next.last_result = res_code;
            case (state.phase)
                mcas_pkg::PH_INIT:
                begin
                    if (sub_eff == mcas_pkg::SUB_ISSUE)
                    begin
                        if (item.call_ok)
                            state_next.sub_step = mcas_pkg::SUB_WAIT;
                        else if (retry_base != mcas_pkg::RETRY_SAT)
                            state_next.retry_count = retry_inc;
                    end
                    else if (sub_eff == mcas_pkg::SUB_WAIT)
                    begin
                        if (ev_ioe)
                        begin
                            state_next.sub_step = mcas_pkg::SUB_ENTRY;
                            if (state.access_mode == mcas_pkg::MODE_INIT)
                                state_next.phase = mcas_pkg::PH_IDLE;
                            else if (!dev_pending)
                                state_next.phase = mcas_pkg::PH_DIR;
                            else
                                state_next.phase = mcas_pkg::PH_CHECK;
                        end
                        else if (ev_new)
                        begin
                            state_next.new_card_flag = 1'b1;
                            state_next.sub_step      = mcas_pkg::SUB_ENTRY;
                            if (state.access_mode == mcas_pkg::MODE_INIT)
                                state_next.phase = mcas_pkg::PH_IDLE;
                            else
                                state_next.phase = mcas_pkg::PH_CHECK;
                        end
                        else if (ev_tmo)
                        begin
                            state_next.phase    = mcas_pkg::PH_IDLE;
                            state_next.sub_step = mcas_pkg::SUB_ENTRY;
                        end
                        else if (ev_err)
                        begin
                            state_next.sub_step = mcas_pkg::SUB_ISSUE;
                        end
                    end
                end
                mcas_pkg::PH_CHECK:
                begin
                    if (sub_eff == mcas_pkg::SUB_ISSUE)
                    begin
                        if (item.call_ok)
                            state_next.sub_step = mcas_pkg::SUB_WAIT;
                    end
                    else if (sub_eff == mcas_pkg::SUB_WAIT)
                    begin
                        if (ev_ioe)
                        begin
                            state_next.phase    = mcas_pkg::PH_LOAD;
                            state_next.sub_step = mcas_pkg::SUB_ENTRY;
                        end
                        else if (ev_tmo)
                        begin
                            state_next.phase    = mcas_pkg::PH_IDLE;
                            state_next.sub_step = mcas_pkg::SUB_ENTRY;
                        end
                        else if (ev_new || ev_err)
                        begin
                            state_next.sub_step = mcas_pkg::SUB_ISSUE;
                        end
                    end
                end
                mcas_pkg::PH_LOAD:
                begin
                    if (sub_eff == mcas_pkg::SUB_ISSUE)
                    begin
                        if (item.call_ok)
                        begin
                            state_next.sub_step     = mcas_pkg::SUB_WAIT;
                            state_next.pending_bits = state.pending_bits | group_bits;
                        end
                    end
                    else if (sub_eff == mcas_pkg::SUB_WAIT)
                    begin
                        if (ev_ioe)
                        begin
                            state_next.phase        = mcas_pkg::PH_DIR;
                            state_next.sub_step     = mcas_pkg::SUB_ENTRY;
                            state_next.pending_bits = state.pending_bits & ~dev_onehot;
                        end
                        else if (ev_new)
                        begin
                            state_next.pending_bits = state.pending_bits | dev_onehot;
                            if (load_retry_left)
                            begin
                                state_next.retry_count = retry_inc;
                                state_next.sub_step    = mcas_pkg::SUB_ISSUE;
                            end
                            else
                            begin
                                state_next.phase    = mcas_pkg::PH_IDLE;
                                state_next.sub_step = mcas_pkg::SUB_ENTRY;
                            end
                        end
                        else if (ev_tmo)
                        begin
                            state_next.phase    = mcas_pkg::PH_IDLE;
                            state_next.sub_step = mcas_pkg::SUB_ENTRY;
                        end
                        else if (ev_err)
                        begin
                            state_next.sub_step = mcas_pkg::SUB_ISSUE;
                        end
                    end
                end
                mcas_pkg::PH_DIR:
                begin
                    state_next.phase    = mcas_pkg::PH_IDLE;
                    state_next.sub_step = mcas_pkg::SUB_ENTRY;
                end
                mcas_pkg::PH_CREATE, mcas_pkg::PH_OPEN:
                begin
                    if (sub_eff == mcas_pkg::SUB_ISSUE)
                    begin
                        if (item.call_ok)
                        begin
                            state_next.phase    = (state.phase == mcas_pkg::PH_CREATE)
                                                  ? mcas_pkg::PH_OPEN : mcas_pkg::PH_XFER;
                            state_next.sub_step = mcas_pkg::SUB_ENTRY;
                        end
                        else if (!file_give_up)
                        begin
                            state_next.retry_count = retry_inc;
                        end
                        else
                        begin
                            state_next.phase    = mcas_pkg::PH_IDLE;
                            state_next.sub_step = mcas_pkg::SUB_ENTRY;
                        end
                    end
                end
                mcas_pkg::PH_XFER:
                begin
                    case (sub_eff)
                        mcas_pkg::SUB_ISSUE:
                        begin
                            if (item.call_ok)
                            begin
                                state_next.retry_count = '0;
                                state_next.sub_step    = mcas_pkg::SUB_WAIT;
                            end
                            else if (!file_give_up)
                            begin
                                state_next.retry_count = retry_inc;
                            end
                            else
                            begin
                                state_next.phase    = mcas_pkg::PH_IDLE;
                                state_next.sub_step = mcas_pkg::SUB_ENTRY;
                            end
                        end
                        mcas_pkg::SUB_WAIT:
                        begin
                            if (item.call_ok && xfer_mode_ok)
                            begin
                                state_next.sub_step = mcas_pkg::SUB_DATA;
                            end
                            else if (!file_give_up)
                            begin
                                state_next.retry_count = retry_inc;
                            end
                            else
                            begin
                                state_next.phase    = mcas_pkg::PH_IDLE;
                                state_next.sub_step = mcas_pkg::SUB_ENTRY;
                            end
                        end
                        default:
                        begin
                            if (ev_ioe || ev_tmo || ev_new)
                            begin
                                state_next.phase    = mcas_pkg::PH_IDLE;
                                state_next.sub_step = mcas_pkg::SUB_ENTRY;
                            end
                            else if (ev_err)
                            begin
                                state_next.sub_step = mcas_pkg::SUB_ISSUE;
                            end
                        end
                    endcase
                end
                default:
                begin
                    state_next.phase = state.phase;
                end
            endcase
        end
    end

    assign result.accepted     = req_taken;
    assign result.result_code  = tick_active ? res_code : state.last_result;
    assign result.is_idle      = (state_next.phase == mcas_pkg::PH_IDLE);
    assign result.action       = action;
    assign result.close_file   = close_file;
    assign result.pending_mask = state_next.pending_bits;

endmodule

/* rtl/core/memory_card_access_sequencer_core.sv */
// ----------------------------------------------------------------------------
// memory_card_access_sequencer_core
// Sequencer that walks a memory-card access through its phases, one item at a time.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the item channel. A request (op = 0) is taken only while
// the sequencer is idle and latches the access mode and the card device; a
// tick (op = 1) reports the outcome of the primitive issued in the current
// phase together with any card event. Every item produces exactly one
// result transfer on the result channel: the accepted flag, the result
// code, the idle flag, the primitive issued, the file close flag and the
// per-device pending mask.
// Retry limits are written on the configuration channel, which is always
// ready; index 0 holds the file retry limit, index 1 the load retry limit.
// An item transferred on the item channel waits in the input register; the
// phase logic then computes the next state and the result, which are
// registered together in the result register. Throughput is one item per
// cycle while the receiver takes results, since the state updates per item.
// When the receiver stalls, the result register holds its transfer and the
// input register keeps one more item; the item channel drops ready only
// when both are full. Reset empties both stages, returns the sequencer to
// idle, sets every pending bit and restores the default retry limits.
// ----------------------------------------------------------------------------
module memory_card_access_sequencer_core (
    input  logic          clk,
    input  logic          rst_n,
    mcas_item_if.sink     item,
    mcas_result_if.source result,
    mcas_cfg_if.sink      cfg
);

    // Input stage.
    logic                 in_valid_reg;
    logic                 in_valid_next;
    mcas_pkg::item_t      in_item_reg;

    // Result stage.
    logic                 out_valid_reg;
    logic                 out_valid_next;
    mcas_pkg::result_t    out_item_reg;
    mcas_pkg::result_t    step_result;

    // Sequencer state.
    mcas_pkg::seq_state_t state_reg;
    mcas_pkg::seq_state_t state_next;
    mcas_pkg::cfg_t       limits;

    logic                 item_xfer;
    logic                 stage_fire;

    mcas_cfg_regs u_cfg_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .limits (limits)
    );

    mcas_step u_step (
        .state      (state_reg),
        .item       (in_item_reg),
        .limits     (limits),
        .state_next (state_next),
        .result     (step_result)
    );

    // The held item is processed when the result register is free or is
    // being emptied in this cycle.
    assign stage_fire = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || stage_fire;
    assign item_xfer  = item.valid && item.ready;

    assign in_valid_next  = item_xfer || (in_valid_reg && !stage_fire);
    assign out_valid_next = stage_fire || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
            state_reg.phase         <= mcas_pkg::PH_IDLE;
            state_reg.sub_step      <= mcas_pkg::SUB_ENTRY;
            state_reg.access_mode   <= '0;
            state_reg.device_reg    <= '0;
            state_reg.pending_bits  <= mcas_pkg::PENDING_RESET;
            state_reg.retry_count   <= '0;
            state_reg.new_card_flag <= 1'b0;
            state_reg.last_result   <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (stage_fire)
            begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            in_item_reg.op         <= item.op;
            in_item_reg.req_mode   <= item.req_mode;
            in_item_reg.device     <= item.device;
            in_item_reg.call_ok    <= item.call_ok;
            in_item_reg.card_event <= item.card_event;
        end
        if (stage_fire)
        begin
            out_item_reg <= step_result;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.accepted     = out_item_reg.accepted;
    assign result.result_code  = out_item_reg.result_code;
    assign result.is_idle      = out_item_reg.is_idle;
    assign result.action       = out_item_reg.action;
    assign result.close_file   = out_item_reg.close_file;
    assign result.pending_mask = out_item_reg.pending_mask;

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the memory-card access sequencer core.
// A queue of pending items feeds a clocked driver. An in-bench model of the
// phase chains predicts one result per transferred item. A clocked monitor
// compares every result transfer against the oldest prediction. Both sides
// idle in random bursts, and the retry limits change between traffic bursts.
// ----------------------------------------------------------------------------
module tb;
    import mcas_pkg::*;

    // Stimulus flavors for one access sequence.
    typedef enum int {
        MIX_GOOD,
        MIX_FLAKY,
        MIX_DEAD,
        MIX_SWAP
    } mix_t;

    localparam int LONG_HOLD    = 150;
    localparam int DRAIN_CYCLES = 4;
    localparam int BURST_ITEMS  = 115;
    localparam int NUM_BURSTS   = 7;

    logic clk = 1'b0;
    logic rst_n;

    mcas_item_if   item_ch ();
    mcas_result_if result_ch ();
    mcas_cfg_if    cfg_ch ();

    memory_card_access_sequencer_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always #2 clk = ~clk;

    // Items waiting to be driven, and results predicted but not yet seen.
    item_t   pending_items[$];
    result_t expected_results[$];

    int items_pushed   = 0;
    int results_seen   = 0;
    int mismatch_count = 0;

    // The last traffic burst runs with no idling on either side.
    logic calm = 1'b0;

    int src_gap;
    int sink_gap;

    // Long receiver hold-off: each new request restarts the countdown.
    int hold_requests = 0;
    int hold_served;
    int hold_left;

    // Shadow state of the sequencer and its retry limits.
    phase_t                seq_phase;
    sub_t                  seq_sub;
    logic [MODE_W-1:0]     seq_mode;
    logic [DEV_W-1:0]      seq_dev;
    logic [MASK_W-1:0]     seq_pend;
    logic [RETRY_W-1:0]    seq_retry;
    logic                  seq_new_card;
    logic [RESULT_W-1:0]   seq_last;
    logic [RETRY_W-1:0]    lim_file;
    logic [LOAD_LIM_W-1:0] lim_load;

    function automatic void enter_phase(phase_t ph);
        seq_phase = ph;
        seq_sub   = SUB_ENTRY;
    endfunction

    // Shared retry rule of create, open, seek and transfer; true on give-up.
    function automatic bit file_give_up();
        if (seq_retry >= lim_file)
            return 1'b1;
        seq_retry++;
        return 1'b0;
    endfunction

    // Applies one item to the shadow state and returns the result it causes.
    function automatic result_t advance_sequencer(item_t it);
        result_t             r;
        logic [RESULT_W-1:0] res;
        r   = '0;
        res = RES_BUSY;
        if (it.op == OP_REQUEST) begin
            if (seq_phase == PH_IDLE) begin
                r.accepted   = 1'b1;
                seq_mode     = it.req_mode;
                seq_dev      = it.device;
                seq_new_card = 1'b0;
                if (it.req_mode <= MODE_DIR)
                    enter_phase(PH_INIT);
                else if (it.req_mode <= MODE_WRITE)
                    enter_phase(PH_OPEN);
                else if (it.req_mode == MODE_CREATE)
                    enter_phase(PH_CREATE);
            end
        end
        else if (seq_phase != PH_IDLE) begin
            if (seq_sub == SUB_ENTRY && seq_phase != PH_DIR) begin
                seq_retry = '0;
                seq_sub   = SUB_ISSUE;
            end
            case (seq_phase)
                PH_INIT:
                begin
                    if (seq_sub == SUB_ISSUE) begin
                        r.action = ACT_INFO;
                        if (it.call_ok)
                            seq_sub = SUB_WAIT;
                        else if (seq_retry < RETRY_SAT)
                            seq_retry++;
                    end
                    else if (seq_sub == SUB_WAIT) begin
                        if (it.card_event == EV_IOE) begin
                            if (seq_mode == MODE_INIT) begin
                                res = RES_READY;
                                enter_phase(PH_IDLE);
                            end
                            else if (seq_dev < NUM_DEVICES && !seq_pend[seq_dev])
                                enter_phase(PH_DIR);
                            else
                                enter_phase(PH_CHECK);
                        end
                        else if (it.card_event == EV_NEW) begin
                            seq_new_card = 1'b1;
                            if (seq_mode == MODE_INIT) begin
                                res = RES_NEW_CARD;
                                enter_phase(PH_IDLE);
                            end
                            else
                                enter_phase(PH_CHECK);
                        end
                        else if (it.card_event == EV_TMO) begin
                            res = RES_ABSENT;
                            enter_phase(PH_IDLE);
                        end
                        else if (it.card_event == EV_ERR)
                            seq_sub = SUB_ISSUE;
                    end
                end
                PH_CHECK:
                begin
                    if (seq_sub == SUB_ISSUE) begin
                        r.action = ACT_CLEAR;
                        if (it.call_ok)
                            seq_sub = SUB_WAIT;
                    end
                    else if (seq_sub == SUB_WAIT) begin
                        if (it.card_event == EV_IOE)
                            enter_phase(PH_LOAD);
                        else if (it.card_event == EV_TMO) begin
                            res = RES_ABSENT;
                            enter_phase(PH_IDLE);
                        end
                        else if (it.card_event == EV_NEW || it.card_event == EV_ERR)
                            seq_sub = SUB_ISSUE;
                    end
                end
                PH_LOAD:
                begin
                    if (seq_sub == SUB_ISSUE) begin
                        r.action = ACT_LOAD;
                        if (it.call_ok) begin
                            seq_sub  = SUB_WAIT;
                            seq_pend = seq_pend |
                                       ((seq_dev[2] ? GROUP_HIGH : GROUP_LOW) & DEV_MASK);
                        end
                    end
                    else if (seq_sub == SUB_WAIT) begin
                        if (it.card_event == EV_IOE) begin
                            enter_phase(PH_DIR);
                            if (seq_dev < NUM_DEVICES)
                                seq_pend[seq_dev] = 1'b0;
                        end
                        else if (it.card_event == EV_NEW) begin
                            if (seq_dev < NUM_DEVICES)
                                seq_pend[seq_dev] = 1'b1;
                            if (seq_retry < lim_load) begin
                                seq_retry++;
                                seq_sub = SUB_ISSUE;
                            end
                            else begin
                                res = RES_UNFORMATTED;
                                enter_phase(PH_IDLE);
                            end
                        end
                        else if (it.card_event == EV_TMO) begin
                            res = RES_ABSENT;
                            enter_phase(PH_IDLE);
                        end
                        else if (it.card_event == EV_ERR)
                            seq_sub = SUB_ISSUE;
                    end
                end
                PH_DIR:
                begin
                    r.action = ACT_DIR;
                    res = seq_new_card ? RES_DIR_NEW : RES_DIR_OK;
                    enter_phase(PH_IDLE);
                end
                PH_CREATE:
                begin
                    if (seq_sub == SUB_ISSUE) begin
                        r.action = ACT_CREATE;
                        if (it.call_ok) begin
                            r.close_file = 1'b1;
                            enter_phase(PH_OPEN);
                        end
                        else if (file_give_up()) begin
                            res = RES_CREATE_FAIL;
                            enter_phase(PH_IDLE);
                        end
                    end
                end
                PH_OPEN:
                begin
                    if (seq_sub == SUB_ISSUE) begin
                        r.action = ACT_OPEN;
                        if (it.call_ok)
                            enter_phase(PH_XFER);
                        else if (file_give_up()) begin
                            res = RES_OPEN_FAIL;
                            enter_phase(PH_IDLE);
                        end
                    end
                end
                default:
                begin
                    if (seq_sub == SUB_ISSUE) begin
                        r.action = ACT_SEEK;
                        if (it.call_ok) begin
                            seq_retry = '0;
                            seq_sub   = SUB_WAIT;
                        end
                        else if (file_give_up()) begin
                            res = RES_SEEK_FAIL;
                            enter_phase(PH_IDLE);
                        end
                    end
                    else if (seq_sub == SUB_WAIT) begin
                        r.action = ACT_TRANSFER;
                        if (it.call_ok && seq_mode >= MODE_READ && seq_mode <= MODE_CREATE)
                            seq_sub = SUB_DATA;
                        else if (file_give_up()) begin
                            res          = RES_IO_FAIL;
                            r.close_file = 1'b1;
                            enter_phase(PH_IDLE);
                        end
                    end
                    else begin
                        // Waiting for the data phase to finish; any end closes the file.
                        if (it.card_event == EV_IOE) begin
                            res          = RES_DONE;
                            r.close_file = 1'b1;
                            enter_phase(PH_IDLE);
                        end
                        else if (it.card_event == EV_TMO) begin
                            res          = RES_ABSENT;
                            r.close_file = 1'b1;
                            enter_phase(PH_IDLE);
                        end
                        else if (it.card_event == EV_NEW) begin
                            res          = RES_IO_FAIL;
                            r.close_file = 1'b1;
                            enter_phase(PH_IDLE);
                        end
                        else if (it.card_event == EV_ERR)
                            seq_sub = SUB_ISSUE;
                    end
                end
            endcase
            seq_last = res;
        end
        r.result_code  = seq_last;
        r.is_idle      = (seq_phase == PH_IDLE);
        r.pending_mask = seq_pend;
        return r;
    endfunction

    function automatic void push_item(logic op, logic [MODE_W-1:0] mode,
                                      logic [DEV_W-1:0] dev, logic ok,
                                      logic [EVENT_W-1:0] ev);
        pending_items.push_back('{op: op, req_mode: mode, device: dev,
                                  call_ok: ok, card_event: ev});
        items_pushed++;
    endfunction

    function automatic logic [EVENT_W-1:0] pick_event(mix_t mix);
        int roll;
        roll = $urandom_range(19, 0);
        if (mix == MIX_SWAP && roll < 10)
            return EV_NEW;
        if (roll < 8)
            return EV_IOE;
        if (roll < 11)
            return EV_NONE;
        if (roll < 13)
            return EV_ERR;
        if (roll < 14)
            return EV_TMO;
        if (roll < 17)
            return EV_NEW;
        if (roll < 19)
            return EVENT_W'($urandom_range(7, EV_NEW + 1));
        return EVENT_W'($urandom_range(7, 0));
    endfunction

    function automatic logic pick_ok(mix_t mix);
        case (mix)
            MIX_GOOD:  return $urandom_range(7, 0) != 0;
            MIX_FLAKY: return $urandom_range(1, 0) != 0;
            MIX_DEAD:  return 1'b0;
            default:   return $urandom_range(3, 0) != 0;
        endcase
    endfunction

    // Queues whole access sequences: a request followed by a run of ticks
    // whose outcomes are shaped by a flavor, with some noise mixed in.
    task automatic queue_access_burst(int n);
        int                count;
        int                len;
        int                roll;
        mix_t              mix;
        logic [MODE_W-1:0] mode;
        count = 0;
        while (count < n) begin
            roll = $urandom_range(7, 0);
            if (roll < 4)
                mix = MIX_GOOD;
            else if (roll < 6)
                mix = MIX_FLAKY;
            else if (roll == 6)
                mix = MIX_DEAD;
            else
                mix = MIX_SWAP;
            if ($urandom_range(9, 0) == 0)
                mode = MODE_W'($urandom_range(7, MODE_CREATE + 1));
            else
                mode = MODE_W'($urandom_range(MODE_CREATE, MODE_INIT));
            push_item(OP_REQUEST, mode, DEV_W'($urandom_range(7, 0)),
                      1'($urandom_range(1, 0)), EVENT_W'($urandom_range(7, 0)));
            count++;
            len = (mix == MIX_DEAD) ? $urandom_range(45, 20) : $urandom_range(20, 3);
            repeat (len) begin
                if ($urandom_range(15, 0) == 0)
                    push_item(1'($urandom_range(1, 0)), MODE_W'($urandom_range(7, 0)),
                              DEV_W'($urandom_range(7, 0)), 1'($urandom_range(1, 0)),
                              EVENT_W'($urandom_range(7, 0)));
                else
                    push_item(OP_TICK, MODE_W'($urandom_range(7, 0)),
                              DEV_W'($urandom_range(7, 0)), pick_ok(mix), pick_event(mix));
                count++;
            end
        end
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        // The write took effect at this edge, with the sequencer pipeline empty.
        if (idx == CFG_FILE_RETRY)
            lim_file = val;
        else if (idx == CFG_LOAD_RETRY)
            lim_load = val[LOAD_LIM_W-1:0];
        cfg_ch.valid <= 1'b0;
    endtask

    // Sender pause: nothing more goes out until a result has been seen for every item.
    task automatic wait_drained();
        wait (results_seen == items_pushed);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Item driver. A transfer happens when valid and ready are both high at
    // the edge; the model is advanced right then, so predictions stay in
    // transfer order. Valid stays up until its transfer.
    always @(posedge clk or negedge rst_n) begin : item_driver
        item_t   nxt;
        result_t want;
        if (!rst_n) begin
            item_ch.valid <= 1'b0;
            src_gap       <= 0;
        end
        else begin
            if (item_ch.valid && item_ch.ready) begin
                want = advance_sequencer('{op: item_ch.op, req_mode: item_ch.req_mode,
                                           device: item_ch.device, call_ok: item_ch.call_ok,
                                           card_event: item_ch.card_event});
                expected_results.push_back(want);
            end
            if (!item_ch.valid || item_ch.ready) begin
                if (src_gap != 0) begin
                    src_gap       <= src_gap - 1;
                    item_ch.valid <= 1'b0;
                end
                else if (!calm && $urandom_range(9, 0) == 0) begin
                    src_gap       <= $urandom_range(18, 0);
                    item_ch.valid <= 1'b0;
                end
                else if (pending_items.size() != 0) begin
                    nxt = pending_items.pop_front();
                    item_ch.op         <= nxt.op;
                    item_ch.req_mode   <= nxt.req_mode;
                    item_ch.device     <= nxt.device;
                    item_ch.call_ok    <= nxt.call_ok;
                    item_ch.card_event <= nxt.card_event;
                    item_ch.valid      <= 1'b1;
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    // Counts down the long receiver hold-off in cycles.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hold_served <= 0;
            hold_left   <= 0;
        end
        else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= LONG_HOLD;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Result monitor. Each result transfer is checked against the oldest
    // prediction; ready drops during random stalls and the long hold-off.
    always @(posedge clk or negedge rst_n) begin : result_monitor
        result_t got;
        result_t want;
        if (!rst_n) begin
            result_ch.ready <= 1'b0;
            sink_gap        <= 0;
        end
        else begin
            if (result_ch.valid && result_ch.ready) begin
                got = '{accepted: result_ch.accepted, result_code: result_ch.result_code,
                        is_idle: result_ch.is_idle, action: result_ch.action,
                        close_file: result_ch.close_file,
                        pending_mask: result_ch.pending_mask};
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result with nothing expected: acc=%0d res=%0d idle=%0d act=%0d close=%0d mask=%02h",
                                 $realtime, got.accepted, got.result_code, got.is_idle,
                                 got.action, got.close_file, got.pending_mask);
                end
                else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: result %0d mismatch: expected acc=%0d res=%0d idle=%0d act=%0d close=%0d mask=%02h, got acc=%0d res=%0d idle=%0d act=%0d close=%0d mask=%02h",
                                     $realtime, results_seen,
                                     want.accepted, want.result_code, want.is_idle,
                                     want.action, want.close_file, want.pending_mask,
                                     got.accepted, got.result_code, got.is_idle,
                                     got.action, got.close_file, got.pending_mask);
                    end
                end
            end
            if (sink_gap != 0) begin
                sink_gap        <= sink_gap - 1;
                result_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(11, 0) == 0) begin
                sink_gap        <= $urandom_range(18, 0);
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= (hold_left == 0);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        int                    k;
        logic [CFG_DATA_W-1:0] file_val;
        logic [CFG_DATA_W-1:0] load_val;

        // Every input known from time zero; reset held low at the start.
        rst_n              = 1'b0;
        item_ch.valid      = 1'b0;
        item_ch.op         = OP_REQUEST;
        item_ch.req_mode   = MODE_INIT;
        item_ch.device     = '0;
        item_ch.call_ok    = 1'b0;
        item_ch.card_event = EV_NONE;
        result_ch.ready    = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_FILE_RETRY;
        cfg_ch.data        = '0;

        seq_phase    = PH_IDLE;
        seq_sub      = SUB_ENTRY;
        seq_mode     = '0;
        seq_dev      = '0;
        seq_pend     = PENDING_RESET;
        seq_retry    = '0;
        seq_new_card = 1'b0;
        seq_last     = RES_ABSENT;
        lim_file     = FILE_RETRY_RESET;
        lim_load     = LOAD_RETRY_RESET;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, at the reset limits. A tick while idle repeats the
        // held result code.
        push_item(OP_TICK, MODE_INIT, 3'd0, 1'b1, EV_IOE);
        // Init on the last device, a request while busy that must be dropped,
        // then a new card that ends the init access.
        push_item(OP_REQUEST, MODE_INIT, 3'd7, 1'b0, EV_NONE);
        push_item(OP_REQUEST, MODE_READ, 3'd2, 1'b1, EV_IOE);
        push_item(OP_TICK, MODE_INIT, 3'd0, 1'b1, EV_NONE);
        push_item(OP_TICK, MODE_INIT, 3'd0, 1'b0, EV_NEW);
        // Directory read on an upper-port device: init, check, load of the
        // upper group, pending bit cleared, directory listed.
        push_item(OP_REQUEST, MODE_DIR, 3'd4, 1'b0, EV_NONE);
        push_item(OP_TICK, MODE_INIT, 3'd0, 1'b1, EV_NONE);
        push_item(OP_TICK, MODE_INIT, 3'd0, 1'b0, EV_IOE);
        push_item(OP_TICK, MODE_INIT, 3'd0, 1'b1, EV_NONE);
        push_item(OP_TICK, MODE_INIT, 3'd0, 1'b0, EV_IOE);
        push_item(OP_TICK, MODE_INIT, 3'd0, 1'b1, EV_NONE);
        push_item(OP_TICK, MODE_INIT, 3'd0, 1'b0, EV_IOE);
        push_item(OP_TICK, MODE_INIT, 3'd0, 1'b0, EV_NONE);
        // A mode beyond create is taken but leaves the sequencer idle.
        push_item(OP_REQUEST, 3'd7, 3'd1, 1'b1, 3'd7);
        // Full write: open, seek, transfer, an unknown event, then io done.
        push_item(OP_REQUEST, MODE_WRITE, 3'd0, 1'b0, EV_NONE);
        push_item(OP_TICK, MODE_INIT, 3'd0, 1'b1, EV_NONE);
        push_item(OP_TICK, MODE_INIT, 3'd0, 1'b1, EV_NONE);
        push_item(OP_TICK, MODE_INIT, 3'd0, 1'b1, EV_NONE);
        push_item(OP_TICK, MODE_INIT, 3'd0, 1'b0, 3'd5);
        push_item(OP_TICK, MODE_INIT, 3'd0, 1'b0, EV_IOE);
        // Create that succeeds and closes the fresh file before opening it.
        push_item(OP_REQUEST, MODE_CREATE, 3'd3, 1'b0, EV_NONE);
        push_item(OP_TICK, MODE_INIT, 3'd0, 1'b1, EV_NONE);
        wait_drained();

        // Random bursts, each under its own pair of retry limits.
        for (k = 0; k < NUM_BURSTS; k++) begin
            case (k)
                0:
                begin
                    file_val = '0;
                    load_val = '0;
                end
                1:
                begin
                    file_val = 5'd31;
                    load_val = 5'd15;
                end
                2:
                begin
                    file_val = 5'd1;
                    load_val = 5'h12;   // upper bit beyond the load field is ignored
                end
                4:
                begin
                    file_val = 5'd3;
                    load_val = 5'd1;
                end
                6:
                begin
                    file_val = FILE_RETRY_RESET;
                    load_val = CFG_DATA_W'(LOAD_RETRY_RESET);
                end
                default:
                begin
                    file_val = CFG_DATA_W'($urandom_range(31, 0));
                    load_val = CFG_DATA_W'($urandom_range(31, 0));
                end
            endcase
            write_reg(CFG_FILE_RETRY, file_val);
            write_reg(CFG_LOAD_RETRY, load_val);
            if (k == NUM_BURSTS - 1)
                calm <= 1'b1;
            queue_access_burst(BURST_ITEMS);
            if (k == 1 || k == 4) begin
                // Stall the receiver long enough for the block to back up
                // its input while the driver keeps offering items.
                repeat (20) @(posedge clk);
                hold_requests <= hold_requests + 1;
            end
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
